// ----- rtl/core/sgi_pkg.sv -----
// Shared widths and sideband types for the segment intersection pipeline.
package sgi_pkg;

    localparam int unsigned CoordW = 32;           // Q16.16 coordinate
    localparam int unsigned DiffW  = CoordW + 1;   // coordinate difference
    localparam int unsigned ProdW  = 2 * DiffW;    // difference product
    localparam int unsigned DistW  = ProdW + 1;    // d1, d2, dot products, |e|^2
    localparam int unsigned SumW   = DistW + 1;    // |d1| + |d2|
    localparam int unsigned FracW  = 32;           // Q0.32 fraction

    // sideband carried alongside the interpolation lanes
    typedef struct packed {
        logic                     kill;
        logic                     neg_x;
        logic                     neg_y;
        logic signed [CoordW-1:0] bx1;
        logic signed [CoordW-1:0] by1;
        logic signed [CoordW-1:0] ax1;
        logic signed [CoordW-1:0] ay1;
        logic signed [DiffW-1:0]  ex;
        logic signed [DiffW-1:0]  ey;
        logic [DistW-1:0]         den;
    } t_lerp_sb;

    // sideband carried alongside the along_a divider
    typedef struct packed {
        logic                     kill;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic [FracW-1:0]         tq;
    } t_frac_sb;

endpackage

// ----- rtl/core/sgi_delay.sv -----
// Enabled shift-register delay line with synchronous reset.
module sgi_delay #(
    parameter int unsigned W = sgi_pkg::CoordW,
    parameter int unsigned D = sgi_pkg::DiffW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) r_q[k] <= '0;
        end else if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < D; k++) r_q[k] <= r_q[k-1];
        end
    end

    assign o_q = r_q[D-1];

endmodule

// ----- rtl/core/sgi_muldiv.sv -----
// Pipelined floor(num * m / den) for num < den, one bit of m per stage.
module sgi_muldiv #(
    parameter int unsigned N_W = sgi_pkg::SumW,
    parameter int unsigned M_W = sgi_pkg::DiffW
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [N_W-1:0] i_den,
    input  logic [M_W-1:0] i_m,
    output logic [M_W-1:0] o_q
);

    localparam int unsigned RW = N_W + 2;

    logic [N_W-1:0] r_rem [M_W];
    logic [M_W-1:0] r_quo [M_W];
    logic [N_W-1:0] r_num [M_W];
    logic [N_W-1:0] r_den [M_W];
    logic [M_W-1:0] r_m   [M_W];

    genvar k;
    generate
        for (k = 0; k < M_W; k++) begin : g_stage
            logic [N_W-1:0] rem_in, num_in, den_in;
            logic [M_W-1:0] quo_in, m_in;
            logic [RW-1:0]  n_r2, n_s1, n_s2;
            logic           n_ge1, n_ge2;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
                assign num_in = i_num;
                assign den_in = i_den;
                assign m_in   = i_m;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign quo_in = r_quo[k-1];
                assign num_in = r_num[k-1];
                assign den_in = r_den[k-1];
                assign m_in   = r_m[k-1];
            end

            // remainder stays below 3*den after the shift-add
            assign n_r2  = {1'b0, rem_in, 1'b0}
                         + (m_in[M_W-1-k] ? {2'b00, num_in} : RW'(0));
            assign n_s1  = {2'b00, den_in};
            assign n_s2  = {1'b0, den_in, 1'b0};
            assign n_ge1 = (n_r2 >= n_s1);
            assign n_ge2 = (n_r2 >= n_s2);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k] <= num_in;
                    r_den[k] <= den_in;
                    r_m[k]   <= m_in;
                    if (n_ge2) begin
                        r_rem[k] <= N_W'(n_r2 - n_s2);
                        r_quo[k] <= {quo_in[M_W-2:0], 1'b0} + M_W'(2);
                    end else if (n_ge1) begin
                        r_rem[k] <= N_W'(n_r2 - n_s1);
                        r_quo[k] <= {quo_in[M_W-2:0], 1'b0} + M_W'(1);
                    end else begin
                        r_rem[k] <= N_W'(n_r2);
                        r_quo[k] <= {quo_in[M_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_q = r_quo[M_W-1];

endmodule

// ----- rtl/core/sgi_frac_div.sv -----
// Pipelined restoring divider: floor(num * 2^Q_W / den) for num < den.
module sgi_frac_div #(
    parameter int unsigned D_W = sgi_pkg::DistW,
    parameter int unsigned Q_W = sgi_pkg::FracW
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [D_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_q
);

    logic [D_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0] r_quo [Q_W];
    logic [D_W-1:0] r_den [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            logic [D_W-1:0] rem_in, den_in;
            logic [Q_W-1:0] quo_in;
            logic [D_W:0]   n_r2;
            logic           n_ge;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign quo_in = '0;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign quo_in = r_quo[k-1];
                assign den_in = r_den[k-1];
            end

            assign n_r2 = {rem_in, 1'b0};
            assign n_ge = (n_r2 >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= den_in;
                    r_rem[k] <= n_ge ? D_W'(n_r2 - {1'b0, den_in}) : D_W'(n_r2);
                    r_quo[k] <= {quo_in[Q_W-2:0], n_ge};
                end
            end
        end
    endgenerate

    assign o_q = r_quo[Q_W-1];

endmodule

// ----- rtl/core/segment_intersection_unit.sv -----
// Segment intersection pipeline: top level.
//
// Tests two Q16.16 segments A and B for a crossing and returns the hit flag,
// the crossing point and the Q0.32 positions along A (along_a) and B
// (along_b); all result fields are zero when there is no hit. A crossing
// needs d1 and d2 (B's endpoints against A's line) of opposite sign or d1
// zero, d2 nonzero, and 0 <= along_a < 1. The unit is fully pipelined and
// takes one pair per cycle while the output is not stalled. It has four
// stages of differences, products and distance tests, 33 stages of
// bit-serial multiply-divide that form t and the offsets along B, three
// stages that form the interpolated point and project it onto A, 32 stages
// of restoring division for along_a, and the output register. The whole
// pipeline holds while a result is stalled at the output; o_stall is high
// exactly then. Every transfer produces exactly one result transfer, in order.
module segment_intersection_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_a_start_x,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_a_start_y,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_a_end_x,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_a_end_y,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_b_start_x,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_b_start_y,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_b_end_x,
    input  logic signed [sgi_pkg::CoordW-1:0]     i_b_end_y,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_hit,
    output logic signed [sgi_pkg::CoordW-1:0]     o_point_x,
    output logic signed [sgi_pkg::CoordW-1:0]     o_point_y,
    output logic [sgi_pkg::FracW-1:0]             o_along_a,
    output logic [sgi_pkg::FracW-1:0]             o_along_b
);

    localparam int unsigned CW = sgi_pkg::CoordW;
    localparam int unsigned DW = sgi_pkg::DiffW;
    localparam int unsigned PW = sgi_pkg::ProdW;
    localparam int unsigned XW = sgi_pkg::DistW;
    localparam int unsigned SW = sgi_pkg::SumW;
    localparam int unsigned FW = sgi_pkg::FracW;

    // global advance: the pipeline moves unless the output holds a stalled result
    logic en;
    logic r_o_valid;
    assign en      = !r_o_valid || !i_stall;
    assign o_stall = !en;

    // ---- stage 1: coordinate differences
    logic                 r_v1;
    logic signed [DW-1:0] r_ex, r_ey, r_p1x, r_p1y, r_p2x, r_p2y, r_dbx, r_dby;
    logic signed [CW-1:0] r_ax1, r_ay1, r_bx1_1, r_by1_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex    <= DW'(i_a_end_x)   - DW'(i_a_start_x);
            r_ey    <= DW'(i_a_end_y)   - DW'(i_a_start_y);
            r_p1x   <= DW'(i_b_start_x) - DW'(i_a_start_x);
            r_p1y   <= DW'(i_b_start_y) - DW'(i_a_start_y);
            r_p2x   <= DW'(i_b_end_x)   - DW'(i_a_start_x);
            r_p2y   <= DW'(i_b_end_y)   - DW'(i_a_start_y);
            r_dbx   <= DW'(i_b_end_x)   - DW'(i_b_start_x);
            r_dby   <= DW'(i_b_end_y)   - DW'(i_b_start_y);
            r_ax1   <= i_a_start_x;
            r_ay1   <= i_a_start_y;
            r_bx1_1 <= i_b_start_x;
            r_by1_1 <= i_b_start_y;
        end
    end

    // ---- stage 2: products for the normal distances and |e|^2
    logic                 r_v2;
    logic signed [PW-1:0] r_m11, r_m12, r_m21, r_m22, r_exx, r_eyy;
    logic signed [DW-1:0] r_ex2, r_ey2, r_dbx2, r_dby2;
    logic signed [CW-1:0] r_ax2, r_ay2, r_bx1_2, r_by1_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m11   <= PW'(r_ey) * PW'(r_p1x);
            r_m12   <= PW'(r_ex) * PW'(r_p1y);
            r_m21   <= PW'(r_ey) * PW'(r_p2x);
            r_m22   <= PW'(r_ex) * PW'(r_p2y);
            r_exx   <= PW'(r_ex) * PW'(r_ex);
            r_eyy   <= PW'(r_ey) * PW'(r_ey);
            r_ex2   <= r_ex;
            r_ey2   <= r_ey;
            r_dbx2  <= r_dbx;
            r_dby2  <= r_dby;
            r_ax2   <= r_ax1;
            r_ay2   <= r_ay1;
            r_bx1_2 <= r_bx1_1;
            r_by1_2 <= r_by1_1;
        end
    end

    // ---- stage 3: d1, d2 and |e|^2
    logic                 r_v3;
    logic signed [XW-1:0] r_d1, r_d2;
    logic [XW-1:0]        r_den3;
    logic signed [DW-1:0] r_ex3, r_ey3, r_dbx3, r_dby3;
    logic signed [CW-1:0] r_ax3, r_ay3, r_bx1_3, r_by1_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1    <= XW'(r_m11) - XW'(r_m12);
            r_d2    <= XW'(r_m21) - XW'(r_m22);
            r_den3  <= XW'(r_exx) + XW'(r_eyy);
            r_ex3   <= r_ex2;
            r_ey3   <= r_ey2;
            r_dbx3  <= r_dbx2;
            r_dby3  <= r_dby2;
            r_ax3   <= r_ax2;
            r_ay3   <= r_ay2;
            r_bx1_3 <= r_bx1_2;
            r_by1_3 <= r_by1_2;
        end
    end

    // ---- stage 4: side test, magnitudes, |d1| + |d2|
    logic                 r_v4;
    logic [XW-1:0]        n_a1, n_a2;
    logic [SW-1:0]        r_a1, r_s;
    logic [DW-1:0]        r_mx, r_my;
    sgi_pkg::t_lerp_sb    r_sb4, n_sb4;

    assign n_a1 = r_d1[XW-1] ? XW'(-r_d1) : XW'(r_d1);
    assign n_a2 = r_d2[XW-1] ? XW'(-r_d2) : XW'(r_d2);

    always_comb begin
        // B end on A's line, or both ends strictly on one side: no crossing
        n_sb4.kill  = (r_d2 == '0) || ((r_d1 != '0) && (r_d1[XW-1] == r_d2[XW-1]));
        n_sb4.neg_x = r_dbx3[DW-1];
        n_sb4.neg_y = r_dby3[DW-1];
        n_sb4.bx1   = r_bx1_3;
        n_sb4.by1   = r_by1_3;
        n_sb4.ax1   = r_ax3;
        n_sb4.ay1   = r_ay3;
        n_sb4.ex    = r_ex3;
        n_sb4.ey    = r_ey3;
        n_sb4.den   = r_den3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1  <= {1'b0, n_a1};
            r_s   <= {1'b0, n_a1} + {1'b0, n_a2};
            r_mx  <= r_dbx3[DW-1] ? DW'(-r_dbx3) : DW'(r_dbx3);
            r_my  <= r_dby3[DW-1] ? DW'(-r_dby3) : DW'(r_dby3);
            r_sb4 <= n_sb4;
        end
    end

    // ---- interpolation lanes: t, |dx|*t, |dy|*t, one bit per stage
    logic [DW-1:0]     q_x, q_y, q_t;
    logic              v_l;
    sgi_pkg::t_lerp_sb sb_l;

    sgi_muldiv #(.N_W(SW), .M_W(DW)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_a1), .i_den(r_s), .i_m(r_mx), .o_q(q_x)
    );
    sgi_muldiv #(.N_W(SW), .M_W(DW)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_a1), .i_den(r_s), .i_m(r_my), .o_q(q_y)
    );
    // m = 2^32 gives the Q0.32 parameter along B
    sgi_muldiv #(.N_W(SW), .M_W(DW)) u_lane_t (
        .i_clk(i_clk), .i_en(en), .i_num(r_a1), .i_den(r_s),
        .i_m({1'b1, {(DW-1){1'b0}}}), .o_q(q_t)
    );

    sgi_delay #(.W(1), .D(DW)) u_lane_vld (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_v4), .o_q(v_l)
    );
    sgi_delay #(.W($bits(sgi_pkg::t_lerp_sb)), .D(DW)) u_lane_sb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_sb4), .o_q(sb_l)
    );

    // ---- stage P: intersection point
    logic                 r_vp, r_kp;
    logic signed [CW-1:0] r_px, r_py, r_axp, r_ayp;
    logic signed [DW-1:0] r_exp, r_eyp;
    logic [XW-1:0]        r_denp;
    logic [FW-1:0]        r_tq;
    logic [DW:0]          n_px, n_py;

    assign n_px = sb_l.neg_x ? (DW+1)'(sb_l.bx1) - (DW+1)'(q_x)
                             : (DW+1)'(sb_l.bx1) + (DW+1)'(q_x);
    assign n_py = sb_l.neg_y ? (DW+1)'(sb_l.by1) - (DW+1)'(q_y)
                             : (DW+1)'(sb_l.by1) + (DW+1)'(q_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (en) begin
            r_vp <= v_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kp   <= sb_l.kill;
            r_px   <= n_px[CW-1:0];
            r_py   <= n_py[CW-1:0];
            r_axp  <= sb_l.ax1;
            r_ayp  <= sb_l.ay1;
            r_exp  <= sb_l.ex;
            r_eyp  <= sb_l.ey;
            r_denp <= sb_l.den;
            r_tq   <= q_t[FW-1:0];
        end
    end

    // ---- stage Q: projection products
    logic                 r_vq, r_kq;
    logic signed [PW-1:0] r_n1, r_n2;
    logic signed [CW-1:0] r_pxq, r_pyq;
    logic [XW-1:0]        r_denq;
    logic [FW-1:0]        r_tqq;
    logic signed [DW-1:0] n_ux, n_uy;

    assign n_ux = DW'(r_px) - DW'(r_axp);
    assign n_uy = DW'(r_py) - DW'(r_ayp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (en) begin
            r_vq <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kq   <= r_kp;
            r_n1   <= PW'(r_exp) * PW'(n_ux);
            r_n2   <= PW'(r_eyp) * PW'(n_uy);
            r_pxq  <= r_px;
            r_pyq  <= r_py;
            r_denq <= r_denp;
            r_tqq  <= r_tq;
        end
    end

    // ---- stage R: dot product and range test on u
    logic                 r_vr;
    logic [XW-1:0]        r_num, r_denr;
    logic signed [XW-1:0] n_num;
    sgi_pkg::t_frac_sb    r_sbr;

    assign n_num = XW'(r_n1) + XW'(r_n2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (en) begin
            r_vr <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // u below zero, or at or past A's end point
            r_sbr.kill <= r_kq || n_num[XW-1] || (XW'(n_num) >= r_denq);
            r_sbr.px   <= r_pxq;
            r_sbr.py   <= r_pyq;
            r_sbr.tq   <= r_tqq;
            r_num      <= n_num[XW-1] ? '0 : XW'(n_num);
            r_denr     <= r_denq;
        end
    end

    // ---- along_a division
    logic [FW-1:0]     q_u;
    logic              v_f;
    sgi_pkg::t_frac_sb sb_f;

    sgi_frac_div #(.D_W(XW), .Q_W(FW)) u_frac (
        .i_clk(i_clk), .i_en(en), .i_num(r_num), .i_den(r_denr), .o_q(q_u)
    );
    sgi_delay #(.W(1), .D(FW)) u_frac_vld (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_vr), .o_q(v_f)
    );
    sgi_delay #(.W($bits(sgi_pkg::t_frac_sb)), .D(FW)) u_frac_sb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_sbr), .o_q(sb_f)
    );

    // ---- output register
    logic                 r_hit;
    logic signed [CW-1:0] r_ox, r_oy;
    logic [FW-1:0]        r_oa, r_ob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= v_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= !sb_f.kill;
            r_ox  <= sb_f.kill ? '0 : sb_f.px;
            r_oy  <= sb_f.kill ? '0 : sb_f.py;
            r_oa  <= sb_f.kill ? '0 : q_u;
            r_ob  <= sb_f.kill ? '0 : sb_f.tq;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_hit     = r_hit;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
    assign o_along_a = r_oa;
    assign o_along_b = r_ob;

endmodule
